FILE: rtl/grid_astar_path_planner_macros.svh
// Assertion helpers shared by the planner.
`ifndef GRID_ASTAR_PATH_PLANNER_MACROS_SVH
`define GRID_ASTAR_PATH_PLANNER_MACROS_SVH

// Same-cycle implication, checked outside reset.
`define GAP_ASSERT_NOW(lbl, ante, cons, msg) \
  lbl: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) else $error(msg);

// Next-cycle implication, checked outside reset.
`define GAP_ASSERT_NEXT(lbl, ante, cons, msg) \
  lbl: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) else $error(msg);

`endif

FILE: rtl/gap_pkg.sv
package gap_pkg;

  typedef struct packed {
    logic [1:0]  operation;
    logic [5:0]  row;
    logic [5:0]  col;
    logic        cell_free;
    logic [5:0]  dest_row;
    logic [5:0]  dest_col;
    logic [11:0] path_index;
  } in_t;

  typedef struct packed {
    logic [2:0]  status;
    logic [12:0] path_length;
    logic [5:0]  path_row;
    logic [5:0]  path_col;
  } out_t;

  typedef enum logic [1:0] {
    OP_MAP_WR  = 2'd0,
    OP_SEARCH  = 2'd1,
    OP_PATH_RD = 2'd2,
    OP_UNUSED  = 2'd3
  } op_t;

  typedef enum logic [2:0] {
    ST_OK       = 3'd0,
    ST_RANGE    = 3'd1,
    ST_BLOCKED  = 3'd2,
    ST_THERE    = 3'd3,
    ST_NO_PATH  = 3'd4,
    ST_OVERFLOW = 3'd5
  } status_t;

  // Neighbor order of expansion.
  typedef enum logic [1:0] {DIR_N, DIR_S, DIR_E, DIR_W} dir_t;

  // Direction of the step from a cell to its parent.
  typedef enum logic [1:0] {PAR_E, PAR_N, PAR_W, PAR_S} par_t;

  localparam logic [9:0] COST_UNREACHED = 10'h3FF;
  localparam logic [9:0] COST_MAX       = 10'd1022;

  typedef enum logic [4:0] {
    S_INIT, S_IDLE, S_DISP, S_RD_FIN, S_CHK_D, S_CHK_E, S_CLEAR, S_SEED,
    S_POP, S_POPW, S_LATCH, S_NB, S_NBW, S_INS_RD, S_INS_CMP, S_INS_PUT,
    S_TR, S_TR_MV
  } ctl_state_t;

  typedef enum logic [3:0] {
    C_IDLE, C_INIT_CLR, C_LOAD, C_MAP_WR, C_SRCH_START, C_CHK_D, C_CLEAR,
    C_SEED, C_POP, C_POPW, C_LATCH, C_NB, C_NBW, C_INS_CMP, C_INS_PUT, C_TR
  } dp_cmd_t;

  typedef struct packed {
    dp_cmd_t op;
    logic    tr_move;
    logic    adv_dir;
    logic    fin;
    status_t st;
  } dp_ctl_t;

  typedef struct packed {
    logic [1:0] op;
    logic       range_ok;
    logic       pair_free;
    logic       same_cell;
    logic       sweep_done;
    logic       open_empty;
    logic       open_full;
    logic       nb_ok;
    logic       nb_dest;
    logic       nb_take;
    logic       dir_last;
    logic       ins_zero;
    logic       ins_shift;
    logic       tr_end;
    logic       out_busy;
  } dp_sts_t;

  function automatic logic [6:0] manhattan(input logic [5:0] r, input logic [5:0] c,
                                           input logic [5:0] dr, input logic [5:0] dc);
    logic [5:0] a;
    logic [5:0] b;
    a = (r > dr) ? r - dr : dr - r;
    b = (c > dc) ? c - dc : dc - c;
    return {1'b0, a} + {1'b0, b};
  endfunction

  function automatic par_t back_dir(input dir_t d);
    par_t p;
    unique case (d)
      DIR_N: p = PAR_S;
      DIR_S: p = PAR_N;
      DIR_E: p = PAR_W;
      DIR_W: p = PAR_E;
    endcase
    return p;
  endfunction

endpackage

FILE: rtl/gap_dp.sv
module gap_dp #(
  parameter int ROWS       = 20,
  parameter int COLS       = 20,
  parameter int OPEN_DEPTH = 1024
) (
  input  logic            clk,
  input  logic            rst_n,
  input  gap_pkg::in_t    in_data,
  input  gap_pkg::dp_ctl_t ctl,
  output gap_pkg::dp_sts_t sts,
  output logic            out_valid,
  input  logic            out_ready,
  output gap_pkg::out_t   out_data
);
  import gap_pkg::*;

  localparam int RW    = $clog2(ROWS);
  localparam int CW    = $clog2(COLS);
  localparam int AW    = RW + CW;
  localparam int MAPD  = 1 << AW;
  localparam int CELLS = ROWS * COLS;
  localparam int PW    = $clog2(CELLS);
  localparam int LW    = $clog2(CELLS + 1);
  localparam int OW    = $clog2(OPEN_DEPTH);
  localparam int NW    = $clog2(OPEN_DEPTH + 1);
  localparam int EW    = AW + 10;
  localparam logic [6:0]    ROWS_V  = 7'(ROWS);
  localparam logic [6:0]    COLS_V  = 7'(COLS);
  localparam logic [OW:0]   DEPTH_V = OPEN_DEPTH[OW:0];
  localparam logic [NW-1:0] FULL_V  = OPEN_DEPTH[NW-1:0];
  localparam logic [LW-1:0] TR_LIM  = LW'(CELLS - 1);

  function automatic logic [AW-1:0] cell_of(input logic [5:0] r, input logic [5:0] c);
    return {r[RW-1:0], c[CW-1:0]};
  endfunction

  function automatic logic [OW-1:0] phys(input logic [OW-1:0] h, input logic [NW-1:0] i);
    logic [OW:0] s;
    s = {1'b0, h} + (OW + 1)'(i);
    if (s >= DEPTH_V) s = s - DEPTH_V;
    return s[OW-1:0];
  endfunction

  // Memories
  logic          map_mem    [MAPD];
  logic          closed_mem [MAPD];
  logic [9:0]    cost_mem   [MAPD];
  logic [1:0]    par_mem    [MAPD];
  logic [EW-1:0] open_mem   [OPEN_DEPTH];
  logic [AW-1:0] path_mem   [CELLS];

  logic map_q, closed_q;
  logic [9:0] cost_q;
  logic [1:0] par_q;
  logic [EW-1:0] open_q;
  logic [AW-1:0] path_q;

  // Registers
  in_t             req_r;
  logic [AW-1:0]   sweep_r;
  logic [OW-1:0]   head_r, head_nxt;
  logic [NW-1:0]   cnt_r, cnt_nxt;
  logic [5:0]      cur_row_r, cur_col_r;
  logic [10:0]     gbase_r;
  dir_t            dir_r;
  logic [NW-1:0]   ins_pos_r;
  logic [9:0]      ins_f_r;
  logic [AW-1:0]   ins_cell_r;
  logic [5:0]      tr_row_r, tr_col_r;
  logic [LW-1:0]   trk_r;
  logic [LW-1:0]   len_r, len_nxt;
  logic            src_free_r;
  logic            out_valid_r;
  out_t            out_r;

  // Neighbor and cost logic
  logic [5:0]    nb_row, nb_col;
  logic          nb_ok;
  logic [AW-1:0] nb_cell, src_cell, dst_cell, tr_cell;
  logic [6:0]    hsrc, hcur, hnb;
  logic [10:0]   f_raw;
  logic [9:0]    f_nb;
  logic          take;
  logic          tr_end;
  logic          map_in, srch_in, rd_in;
  logic [12:0]   rd_idx;

  always_comb begin
    nb_row = cur_row_r;
    nb_col = cur_col_r;
    nb_ok  = 1'b0;
    unique case (dir_r)
      DIR_N: begin
        nb_ok  = (cur_row_r != 6'd0);
        nb_row = cur_row_r - 6'd1;
      end
      DIR_S: begin
        nb_ok  = ({1'b0, cur_row_r} + 7'd1) < ROWS_V;
        nb_row = cur_row_r + 6'd1;
      end
      DIR_E: begin
        nb_ok  = ({1'b0, cur_col_r} + 7'd1) < COLS_V;
        nb_col = cur_col_r + 6'd1;
      end
      DIR_W: begin
        nb_ok  = (cur_col_r != 6'd0);
        nb_col = cur_col_r - 6'd1;
      end
    endcase
  end

  assign nb_cell  = cell_of(nb_row, nb_col);
  assign src_cell = cell_of(req_r.row, req_r.col);
  assign dst_cell = cell_of(req_r.dest_row, req_r.dest_col);
  assign tr_cell  = cell_of(tr_row_r, tr_col_r);
  assign hsrc     = manhattan(req_r.row, req_r.col, req_r.dest_row, req_r.dest_col);
  assign hcur     = manhattan(cur_row_r, cur_col_r, req_r.dest_row, req_r.dest_col);
  assign hnb      = manhattan(nb_row, nb_col, req_r.dest_row, req_r.dest_col);
  assign f_raw    = gbase_r + 11'd1 + 11'(hnb);
  assign f_nb     = (f_raw > 11'(COST_MAX)) ? COST_MAX : f_raw[9:0];
  assign take     = !closed_q && map_q && (cost_q > f_nb);
  assign tr_end   = (tr_cell == src_cell) || (trk_r == TR_LIM);

  assign map_in  = ({1'b0, req_r.row} < ROWS_V) && ({1'b0, req_r.col} < COLS_V);
  assign srch_in = map_in && ({1'b0, req_r.dest_row} < ROWS_V) &&
                   ({1'b0, req_r.dest_col} < COLS_V);
  assign rd_in   = ({1'b0, req_r.path_index} < 13'(len_r));
  assign rd_idx  = 13'(len_r) - 13'd1 - {1'b0, req_r.path_index};

  always_comb begin
    sts = '0;
    sts.op = req_r.operation;
    unique case (req_r.operation)
      OP_MAP_WR:  sts.range_ok = map_in;
      OP_SEARCH:  sts.range_ok = srch_in;
      OP_PATH_RD: sts.range_ok = rd_in;
      OP_UNUSED:  sts.range_ok = 1'b0;
    endcase
    sts.pair_free  = src_free_r && map_q;
    sts.same_cell  = (req_r.row == req_r.dest_row) && (req_r.col == req_r.dest_col);
    sts.sweep_done = (sweep_r == '1);
    sts.open_empty = (cnt_r == '0);
    sts.open_full  = (cnt_r == FULL_V);
    sts.nb_ok      = nb_ok;
    sts.nb_dest    = (nb_row == req_r.dest_row) && (nb_col == req_r.dest_col);
    sts.nb_take    = take;
    sts.dir_last   = (dir_r == DIR_W);
    sts.ins_zero   = (ins_pos_r == '0);
    sts.ins_shift  = (open_q[EW-1:AW] > ins_f_r);
    sts.tr_end     = tr_end;
    sts.out_busy   = out_valid_r;
  end

  // Read addresses
  logic [AW-1:0] map_ra, cost_ra;
  logic [OW-1:0] open_ra;
  always_comb begin
    map_ra  = nb_cell;
    cost_ra = nb_cell;
    open_ra = phys(head_r, ins_pos_r - NW'(1));
    if (ctl.op == C_SRCH_START) map_ra = src_cell;
    if (ctl.op == C_CHK_D)      map_ra = dst_cell;
    if (ctl.op == C_POPW)       cost_ra = open_q[AW-1:0];
    if (ctl.op == C_POP)        open_ra = head_r;
  end

  // Write ports
  logic          map_we, map_wd;
  logic [AW-1:0] map_wa;
  logic          cl_we, cl_wd;
  logic [AW-1:0] cl_wa;
  logic          cost_we;
  logic [9:0]    cost_wd;
  logic [AW-1:0] cost_wa;
  logic          par_we;
  logic [1:0]    par_wd;
  logic [AW-1:0] par_wa;
  logic          open_we;
  logic [EW-1:0] open_wd;
  logic [OW-1:0] open_wa;
  logic          path_we;
  logic [AW-1:0] path_wd;

  always_comb begin
    map_we = 1'b0; map_wd = 1'b1; map_wa = sweep_r;
    cl_we = 1'b0; cl_wd = 1'b0; cl_wa = sweep_r;
    cost_we = 1'b0; cost_wd = COST_UNREACHED; cost_wa = sweep_r;
    par_we = 1'b0; par_wd = 2'(PAR_E); par_wa = sweep_r;
    open_we = 1'b0; open_wd = open_q; open_wa = phys(head_r, ins_pos_r);
    path_we = 1'b0; path_wd = tr_cell;
    unique case (ctl.op)
      C_INIT_CLR: map_we = 1'b1;
      C_MAP_WR: begin
        map_we = map_in;
        map_wa = src_cell;
        map_wd = req_r.cell_free;
      end
      C_CLEAR: begin
        cl_we = 1'b1; cost_we = 1'b1; par_we = 1'b1;
      end
      C_SEED: begin
        cost_we = 1'b1; cost_wa = src_cell; cost_wd = 10'(hsrc);
        open_we = 1'b1; open_wa = '0; open_wd = {10'(hsrc), src_cell};
      end
      C_POPW: begin
        cl_we = 1'b1; cl_wa = open_q[AW-1:0]; cl_wd = 1'b1;
      end
      C_NB: begin
        par_we = nb_ok && sts.nb_dest;
        par_wa = nb_cell;
        par_wd = 2'(back_dir(dir_r));
      end
      C_NBW: begin
        cost_we = take; cost_wa = nb_cell; cost_wd = f_nb;
        par_we = take; par_wa = nb_cell; par_wd = 2'(back_dir(dir_r));
      end
      C_INS_CMP: open_we = sts.ins_shift;
      C_INS_PUT: begin
        open_we = 1'b1;
        open_wd = {ins_f_r, ins_cell_r};
      end
      C_TR: begin
        path_we = 1'b1;
        path_wd = tr_end ? src_cell : tr_cell;
      end
      default: ;
    endcase
  end

  always_ff @(posedge clk) begin
    if (map_we) map_mem[map_wa] <= map_wd;
    map_q <= map_mem[map_ra];
  end

  always_ff @(posedge clk) begin
    if (cl_we) closed_mem[cl_wa] <= cl_wd;
    closed_q <= closed_mem[nb_cell];
  end

  always_ff @(posedge clk) begin
    if (cost_we) cost_mem[cost_wa] <= cost_wd;
    cost_q <= cost_mem[cost_ra];
  end

  always_ff @(posedge clk) begin
    if (par_we) par_mem[par_wa] <= par_wd;
    par_q <= par_mem[tr_cell];
  end

  always_ff @(posedge clk) begin
    if (open_we) open_mem[open_wa] <= open_wd;
    open_q <= open_mem[open_ra];
  end

  always_ff @(posedge clk) begin
    if (path_we) path_mem[trk_r[PW-1:0]] <= path_wd;
    path_q <= path_mem[rd_idx[PW-1:0]];
  end

  // Open list bookkeeping
  always_comb begin
    head_nxt = head_r;
    cnt_nxt  = cnt_r;
    unique case (ctl.op)
      C_SEED: begin
        head_nxt = '0;
        cnt_nxt  = NW'(1);
      end
      C_POPW: begin
        head_nxt = ({1'b0, head_r} == DEPTH_V - 1) ? '0 : head_r + OW'(1);
        cnt_nxt  = cnt_r - NW'(1);
      end
      C_INS_PUT: cnt_nxt = cnt_r + NW'(1);
      default: ;
    endcase
  end

  always_comb begin
    len_nxt = len_r;
    if (ctl.op == C_SRCH_START) len_nxt = '0;
    if (ctl.op == C_TR && tr_end) len_nxt = trk_r + LW'(1);
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      sweep_r     <= '0;
      head_r      <= '0;
      cnt_r       <= '0;
      len_r       <= '0;
      dir_r       <= DIR_N;
      out_valid_r <= 1'b0;
    end else begin
      sweep_r <= (ctl.op == C_INIT_CLR || ctl.op == C_CLEAR) ? sweep_r + AW'(1) : '0;
      head_r  <= head_nxt;
      cnt_r   <= cnt_nxt;
      len_r   <= len_nxt;
      if (ctl.op == C_POPW) dir_r <= DIR_N;
      else if (ctl.adv_dir) dir_r <= dir_t'(dir_r + 2'd1);
      if (ctl.fin) out_valid_r <= 1'b1;
      else if (out_ready) out_valid_r <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (ctl.op == C_LOAD) req_r <= in_data;
    if (ctl.op == C_CHK_D) src_free_r <= map_q;
    if (ctl.op == C_POPW) begin
      cur_row_r <= 6'(open_q[AW-1:CW]);
      cur_col_r <= 6'(open_q[CW-1:0]);
    end
    if (ctl.op == C_LATCH) gbase_r <= 11'(cost_q) - 11'(hcur);
    if (ctl.op == C_NBW) begin
      ins_pos_r  <= cnt_r;
      ins_f_r    <= f_nb;
      ins_cell_r <= nb_cell;
    end
    if (ctl.op == C_INS_CMP && sts.ins_shift) ins_pos_r <= ins_pos_r - NW'(1);
    if (ctl.op == C_NB) begin
      tr_row_r <= nb_row;
      tr_col_r <= nb_col;
      trk_r    <= '0;
    end
    if (ctl.tr_move) begin
      trk_r <= trk_r + LW'(1);
      unique case (par_t'(par_q))
        PAR_E: if (({1'b0, tr_col_r} + 7'd1) < COLS_V) tr_col_r <= tr_col_r + 6'd1;
        PAR_N: if (tr_row_r != 6'd0) tr_row_r <= tr_row_r - 6'd1;
        PAR_W: if (tr_col_r != 6'd0) tr_col_r <= tr_col_r - 6'd1;
        PAR_S: if (({1'b0, tr_row_r} + 7'd1) < ROWS_V) tr_row_r <= tr_row_r + 6'd1;
      endcase
    end
    if (ctl.fin) begin
      out_r.status      <= ctl.st;
      out_r.path_length <= 13'(len_nxt);
      if (req_r.operation == OP_PATH_RD && ctl.st == ST_OK) begin
        out_r.path_row <= 6'(path_q[AW-1:CW]);
        out_r.path_col <= 6'(path_q[CW-1:0]);
      end else begin
        out_r.path_row <= '0;
        out_r.path_col <= '0;
      end
    end
  end

  assign out_valid = out_valid_r;
  assign out_data  = out_r;

endmodule

FILE: rtl/gap_ctrl.sv
module gap_ctrl (
  input  logic             clk,
  input  logic             rst_n,
  input  logic             in_valid,
  output logic             in_ready,
  input  gap_pkg::dp_sts_t sts,
  output gap_pkg::dp_ctl_t ctl
);
  import gap_pkg::*;

  ctl_state_t state_r, state_nxt;

  always_ff @(posedge clk) begin
    if (!rst_n) state_r <= S_INIT;
    else        state_r <= state_nxt;
  end

  assign in_ready = (state_r == S_IDLE) && !sts.out_busy;

  always_comb begin
    state_nxt   = state_r;
    ctl         = '0;
    ctl.op      = C_IDLE;
    ctl.st      = ST_OK;
    unique case (state_r)
      S_INIT: begin
        ctl.op = C_INIT_CLR;
        if (sts.sweep_done) state_nxt = S_IDLE;
      end
      S_IDLE: begin
        if (in_valid && in_ready) begin
          ctl.op    = C_LOAD;
          state_nxt = S_DISP;
        end
      end
      S_DISP: begin
        unique case (sts.op)
          OP_MAP_WR: begin
            ctl.op    = C_MAP_WR;
            ctl.fin   = 1'b1;
            ctl.st    = sts.range_ok ? ST_OK : ST_RANGE;
            state_nxt = S_IDLE;
          end
          OP_SEARCH: begin
            ctl.op = C_SRCH_START;
            if (!sts.range_ok) begin
              ctl.fin   = 1'b1;
              ctl.st    = ST_RANGE;
              state_nxt = S_IDLE;
            end else begin
              state_nxt = S_CHK_D;
            end
          end
          OP_PATH_RD: state_nxt = S_RD_FIN;
          OP_UNUSED: begin
            ctl.fin   = 1'b1;
            ctl.st    = ST_RANGE;
            state_nxt = S_IDLE;
          end
        endcase
      end
      S_RD_FIN: begin
        ctl.fin   = 1'b1;
        ctl.st    = sts.range_ok ? ST_OK : ST_RANGE;
        state_nxt = S_IDLE;
      end
      S_CHK_D: begin
        ctl.op    = C_CHK_D;
        state_nxt = S_CHK_E;
      end
      S_CHK_E: begin
        priority if (!sts.pair_free) begin
          ctl.fin   = 1'b1;
          ctl.st    = ST_BLOCKED;
          state_nxt = S_IDLE;
        end else if (sts.same_cell) begin
          ctl.fin   = 1'b1;
          ctl.st    = ST_THERE;
          state_nxt = S_IDLE;
        end else begin
          state_nxt = S_CLEAR;
        end
      end
      S_CLEAR: begin
        ctl.op = C_CLEAR;
        if (sts.sweep_done) state_nxt = S_SEED;
      end
      S_SEED: begin
        ctl.op    = C_SEED;
        state_nxt = S_POP;
      end
      S_POP: begin
        ctl.op = C_POP;
        if (sts.open_empty) begin
          ctl.fin   = 1'b1;
          ctl.st    = ST_NO_PATH;
          state_nxt = S_IDLE;
        end else begin
          state_nxt = S_POPW;
        end
      end
      S_POPW: begin
        ctl.op    = C_POPW;
        state_nxt = S_LATCH;
      end
      S_LATCH: begin
        ctl.op    = C_LATCH;
        state_nxt = S_NB;
      end
      S_NB: begin
        ctl.op = C_NB;
        priority if (!sts.nb_ok) begin
          ctl.adv_dir = 1'b1;
          state_nxt   = sts.dir_last ? S_POP : S_NB;
        end else if (sts.nb_dest) begin
          state_nxt = S_TR;
        end else begin
          state_nxt = S_NBW;
        end
      end
      S_NBW: begin
        ctl.op = C_NBW;
        priority if (!sts.nb_take) begin
          ctl.adv_dir = 1'b1;
          state_nxt   = sts.dir_last ? S_POP : S_NB;
        end else if (sts.open_full) begin
          ctl.fin   = 1'b1;
          ctl.st    = ST_OVERFLOW;
          state_nxt = S_IDLE;
        end else begin
          state_nxt = S_INS_RD;
        end
      end
      S_INS_RD: state_nxt = sts.ins_zero ? S_INS_PUT : S_INS_CMP;
      S_INS_CMP: begin
        ctl.op    = C_INS_CMP;
        state_nxt = sts.ins_shift ? S_INS_RD : S_INS_PUT;
      end
      S_INS_PUT: begin
        ctl.op      = C_INS_PUT;
        ctl.adv_dir = 1'b1;
        state_nxt   = sts.dir_last ? S_POP : S_NB;
      end
      S_TR: begin
        ctl.op = C_TR;
        if (sts.tr_end) begin
          ctl.fin   = 1'b1;
          ctl.st    = ST_OK;
          state_nxt = S_IDLE;
        end else begin
          state_nxt = S_TR_MV;
        end
      end
      S_TR_MV: begin
        ctl.tr_move = 1'b1;
        state_nxt   = S_TR;
      end
    endcase
  end

endmodule

FILE: rtl/grid_astar_path_planner.sv
// Grid path planner. Each request is a map write (mark a cell free or blocked),
// a search (A* from row/col to dest_row/dest_col, Manhattan heuristic, four
// neighbors tried north, south, east, west, open list ordered by f with equal f
// served first in, first out), or a path read (one stored cell, index 0 is the
// source). Every request gives exactly one result carrying a status and the
// current stored path length. After reset the block sweeps its map memory to
// all-free, one entry a cycle, over 2**(clog2(ROWS)+clog2(COLS)) entries (1024 at
// the default 20x20) before it takes the first request. A search that runs
// first sweeps the per-cell cost/closed/parent memories the same way and seeds
// the open list, then pops open-list entries, checks the neighbors of each
// popped cell, makes a sorted insert for each neighbor it improves (moving the
// entries behind it one at a time), and traces the path back from the
// destination. One request is in flight at a time; the result register holds
// a finished result until it is taken, and a new request is taken only while
// that register is empty.
module grid_astar_path_planner #(
  parameter int ROWS       = 20,
  parameter int COLS       = 20,
  parameter int OPEN_DEPTH = 1024
) (
  input  logic          clk,
  input  logic          rst_n,
  input  logic          in_valid,
  output logic          in_ready,
  input  gap_pkg::in_t  in_data,
  output logic          out_valid,
  input  logic          out_ready,
  output gap_pkg::out_t out_data
);
  import gap_pkg::*;

`include "grid_astar_path_planner_macros.svh"

  // Command and status between the sequencer and the datapath
  dp_ctl_t ctl;
  dp_sts_t sts;

  // Sequencer: decode the request, walk the search, trace the path
  gap_ctrl u_ctrl (
    .clk      (clk),
    .rst_n    (rst_n),
    .in_valid (in_valid),
    .in_ready (in_ready),
    .sts      (sts),
    .ctl      (ctl)
  );

  // Datapath: map, cost, parent and open-list memories plus the result register
  gap_dp #(
    .ROWS       (ROWS),
    .COLS       (COLS),
    .OPEN_DEPTH (OPEN_DEPTH)
  ) u_dp (
    .clk       (clk),
    .rst_n     (rst_n),
    .in_data   (in_data),
    .ctl       (ctl),
    .sts       (sts),
    .out_valid (out_valid),
    .out_ready (out_ready),
    .out_data  (out_data)
  );

  // A request is only taken with the result register empty.
  `GAP_ASSERT_NOW(a_accept_empty, in_valid && in_ready, !out_valid, "request taken while result pending")
  // One request in flight: no accept on the cycle after an accept.
  `GAP_ASSERT_NEXT(a_one_inflight, in_valid && in_ready, !in_ready, "second request taken back to back")
  // Status codes stay within the defined set.
  `GAP_ASSERT_NOW(a_status_code, out_valid, out_data.status <= ST_OVERFLOW, "undefined status code")
  // A stored path never exceeds the number of grid cells.
  `GAP_ASSERT_NOW(a_path_len, out_valid, out_data.path_length <= 13'(ROWS * COLS), "path longer than grid")

endmodule

FILE: bench/grid_astar_path_planner_test.sv
module grid_astar_path_planner_test;
  import gap_pkg::*;

  localparam int NROWS = 20;
  localparam int NCOLS = 20;
  localparam int NCELLS = NROWS * NCOLS;
  localparam int OPEN_SIZE = 1024;
  localparam int IN_W = $bits(in_t);
  // Cycles allowed between two results, with ample headroom for a worst-case
  // search with long sorted inserts.
  localparam int CYCLE_LIMIT = 16000000;
  localparam int TAIL_CYCLES = 64;

  logic clk = 1'b0;
  logic rst_n = 1'b0;
  logic in_valid = 1'b0;
  logic in_ready;
  in_t in_data = '0;
  logic out_valid;
  logic out_ready = 1'b0;
  out_t out_data;

  grid_astar_path_planner dut (
    .clk(clk), .rst_n(rst_n),
    .in_valid(in_valid), .in_ready(in_ready), .in_data(in_data),
    .out_valid(out_valid), .out_ready(out_ready), .out_data(out_data)
  );

  always begin
    #5 clk = 1'b1;
    #5 clk = 1'b0;
  end

  // Shadow planner state, kept in step with every accepted request.
  bit free_map[NCELLS];
  bit closed[NCELLS];
  int unsigned cost[NCELLS];
  par_t pdir[NCELLS];
  int unsigned open_f[OPEN_SIZE];
  int unsigned open_c[OPEN_SIZE];
  int unsigned open_n;
  int unsigned path[NCELLS];
  int unsigned path_len;

  out_t pending_results[$];
  int errors = 0;
  int cycles = 0;
  bit quiet = 1'b0;

  function automatic int unsigned manhattan_dist(int unsigned r, int unsigned c,
                                                 int unsigned dr, int unsigned dc);
    return ((r > dr) ? r - dr : dr - r) + ((c > dc) ? c - dc : dc - c);
  endfunction

  // Sorted insert: equal f goes behind the entries already there.
  function automatic bit open_insert(int unsigned cell_id, int unsigned f);
    int unsigned pos;
    if (open_n >= OPEN_SIZE) return 1'b0;
    pos = open_n;
    while (pos > 0 && open_f[pos-1] > f) begin
      open_f[pos] = open_f[pos-1];
      open_c[pos] = open_c[pos-1];
      pos--;
    end
    open_f[pos] = f;
    open_c[pos] = cell_id;
    open_n++;
    return 1'b1;
  endfunction

  // Walk parent directions back from the destination, then store source first.
  function automatic void trace_path(int unsigned src, int unsigned dst);
    int unsigned walk[NCELLS];
    int unsigned cur, k, r, c;
    cur = dst;
    k = 0;
    while (cur != src && k < NCELLS - 1) begin
      r = cur / NCOLS;
      c = cur % NCOLS;
      walk[k++] = cur;
      case (pdir[cur])
        PAR_E: if (c + 1 < NCOLS) c++;
        PAR_N: if (r > 0) r--;
        PAR_W: if (c > 0) c--;
        default: if (r + 1 < NROWS) r++;
      endcase
      cur = r * NCOLS + c;
    end
    walk[k++] = src;
    for (int i = 0; i < k; i++) path[i] = walk[k-1-i];
    path_len = k;
  endfunction

  function automatic status_t plan_route(int unsigned sr, int unsigned sc,
                                         int unsigned dr, int unsigned dc);
    int unsigned src, cur_cell, r, c, f;
    int nr, nc, n;
    path_len = 0;
    if (sr >= NROWS || sc >= NCOLS || dr >= NROWS || dc >= NCOLS) return ST_RANGE;
    if (!free_map[sr*NCOLS+sc] || !free_map[dr*NCOLS+dc]) return ST_BLOCKED;
    if (sr == dr && sc == dc) return ST_THERE;
    for (int i = 0; i < NCELLS; i++) begin
      closed[i] = 1'b0;
      cost[i] = COST_UNREACHED;
      pdir[i] = PAR_E;
    end
    src = sr * NCOLS + sc;
    cost[src] = manhattan_dist(sr, sc, dr, dc);
    open_n = 0;
    void'(open_insert(src, cost[src]));
    while (open_n > 0) begin
      cur_cell = open_c[0];
      open_n--;
      for (int i = 0; i < open_n; i++) begin
        open_f[i] = open_f[i+1];
        open_c[i] = open_c[i+1];
      end
      r = cur_cell / NCOLS;
      c = cur_cell % NCOLS;
      closed[cur_cell] = 1'b1;
      for (int d = 0; d < 4; d++) begin
        nr = r;
        nc = c;
        case (dir_t'(d))
          DIR_N: nr = nr - 1;
          DIR_S: nr = nr + 1;
          DIR_E: nc = nc + 1;
          default: nc = nc - 1;
        endcase
        if (nr < 0 || nr >= NROWS || nc < 0 || nc >= NCOLS) continue;
        n = nr * NCOLS + nc;
        // A neighbor that is the destination ends the search on the spot.
        if (nr == dr && nc == dc) begin
          pdir[n] = back_dir(dir_t'(d));
          trace_path(src, n);
          return ST_OK;
        end
        if (closed[n] || !free_map[n]) continue;
        f = cost[cur_cell] - manhattan_dist(r, c, dr, dc) + 1 + manhattan_dist(nr, nc, dr, dc);
        if (f > COST_MAX) f = COST_MAX;
        if (cost[n] > f) begin
          cost[n] = f;
          pdir[n] = back_dir(dir_t'(d));
          if (!open_insert(n, f)) return ST_OVERFLOW;
        end
      end
    end
    return ST_NO_PATH;
  endfunction

  function automatic out_t predict_result(in_t req);
    out_t res;
    res = '0;
    res.status = ST_RANGE;
    case (op_t'(req.operation))
      OP_MAP_WR: if (req.row < NROWS && req.col < NCOLS) begin
        free_map[req.row*NCOLS+req.col] = req.cell_free;
        res.status = ST_OK;
      end
      OP_SEARCH: res.status = plan_route(req.row, req.col, req.dest_row, req.dest_col);
      OP_PATH_RD: if (req.path_index < path_len) begin
        res.path_row = 6'(path[req.path_index] / NCOLS);
        res.path_col = 6'(path[req.path_index] % NCOLS);
        res.status = ST_OK;
      end
      default: ;
    endcase
    res.path_length = 13'(path_len);
    return res;
  endfunction

  function automatic in_t mk_req(op_t op, int r, int c, bit fr, int dr, int dc, int idx);
    in_t req;
    req.operation = op;
    req.row = 6'(r);
    req.col = 6'(c);
    req.cell_free = fr;
    req.dest_row = 6'(dr);
    req.dest_col = 6'(dc);
    req.path_index = 12'(idx);
    return req;
  endfunction

  // Present one request, hold it until taken, then maybe drop valid for a burst.
  task automatic send_request(in_t req);
    in_valid <= 1'b1;
    in_data <= req;
    do @(posedge clk); while (!in_ready);
    pending_results.push_back(predict_result(req));
    if (!quiet && $urandom_range(0, 3) == 0) begin
      in_valid <= 1'b0;
      repeat ($urandom_range(1, 16)) @(posedge clk);
    end
  endtask

  // Drop valid and hold until every predicted result has come back.
  task automatic drain_results();
    in_valid <= 1'b0;
    do @(posedge clk); while (pending_results.size() != 0);
    repeat (TAIL_CYCLES) @(posedge clk);
  endtask

  function automatic void check_field(string name, int unsigned want, int unsigned got);
    if (want != got) begin
      $display("%0t mismatch %s: expected %0d, actual %0d", $time, name, want, got);
      errors++;
    end
  endfunction

  // Result side: check each accepted result, then pick next cycle's ready.
  int stall_left = 0;
  always @(posedge clk) begin
    out_t want;
    cycles++;
    if (cycles > CYCLE_LIMIT) begin
      $display("tb: failure");
      $finish;
    end else begin
      if (rst_n && out_valid && out_ready) begin
        cycles = 0;
        if (pending_results.size() == 0) begin
          $display("%0t unexpected result: actual %p", $time, out_data);
          errors++;
        end else begin
          want = pending_results.pop_front();
          check_field("status", want.status, out_data.status);
          check_field("path_length", want.path_length, out_data.path_length);
          check_field("path_row", want.path_row, out_data.path_row);
          check_field("path_col", want.path_col, out_data.path_col);
        end
      end
      if (stall_left > 0) begin
        stall_left--;
        out_ready <= 1'b0;
      end else if (!quiet && $urandom_range(0, 7) == 0) begin
        stall_left = $urandom_range(0, 15);
        out_ready <= 1'b0;
      end else begin
        out_ready <= 1'b1;
      end
    end
  end

  // Map writes in range, at the far corners and beyond the grid edges.
  task automatic test_map_writes();
    send_request(mk_req(OP_MAP_WR, 0, 0, 0, 0, 0, 0));
    send_request(mk_req(OP_MAP_WR, 19, 19, 1, 63, 63, 4095));
    send_request(mk_req(OP_MAP_WR, 63, 63, 0, 0, 0, 0));
    send_request(mk_req(OP_MAP_WR, 5, 20, 0, 0, 0, 0));
  endtask

  // Rejections first, then found and unreachable routes.
  task automatic test_search_cases();
    send_request(mk_req(OP_SEARCH, 0, 0, 1, 5, 5, 0));     // blocked source
    send_request(mk_req(OP_SEARCH, 63, 0, 1, 1, 1, 0));    // source off grid
    send_request(mk_req(OP_SEARCH, 1, 1, 1, 0, 20, 0));    // destination off grid
    send_request(mk_req(OP_SEARCH, 3, 3, 1, 3, 3, 0));     // already there
    send_request(mk_req(OP_MAP_WR, 0, 0, 1, 0, 0, 0));
    send_request(mk_req(OP_SEARCH, 0, 0, 0, 19, 19, 0));   // corner to corner
    send_request(mk_req(OP_PATH_RD, 0, 0, 0, 0, 0, 0));
    send_request(mk_req(OP_PATH_RD, 0, 0, 0, 0, 0, 38));
    send_request(mk_req(OP_PATH_RD, 0, 0, 0, 0, 0, 4095));
    // Wall in the destination so the search runs dry.
    send_request(mk_req(OP_MAP_WR, 18, 19, 0, 0, 0, 0));
    send_request(mk_req(OP_MAP_WR, 19, 18, 0, 0, 0, 0));
    send_request(mk_req(OP_SEARCH, 0, 0, 1, 19, 19, 0));
    send_request(mk_req(OP_PATH_RD, 0, 0, 1, 0, 0, 0));
    send_request(mk_req(OP_MAP_WR, 18, 19, 1, 0, 0, 0));
    send_request(mk_req(OP_MAP_WR, 19, 18, 1, 0, 0, 0));
    send_request(mk_req(OP_SEARCH, 0, 0, 1, 0, 1, 0));     // neighbor is destination
    send_request(mk_req(OP_PATH_RD, 0, 0, 1, 0, 0, 1));
  endtask

  task automatic test_unused_op();
    send_request(mk_req(OP_UNUSED, 63, 63, 1, 63, 63, 4095));
  endtask

  // Mostly legal traffic on a map that hovers near a third blocked.
  task automatic test_random_traffic(int count);
    in_t req;
    int pick;
    for (int i = 0; i < count; i++) begin
      req = in_t'(IN_W'({$urandom, $urandom}));
      pick = $urandom_range(0, 99);
      if (pick < 40) begin
        req.operation = OP_MAP_WR;
        req.row = 6'($urandom_range(0, NROWS - 1));
        req.col = 6'($urandom_range(0, NCOLS - 1));
        req.cell_free = ($urandom_range(0, 9) < 7);
      end else if (pick < 65) begin
        req.operation = OP_SEARCH;
        req.row = 6'($urandom_range(0, NROWS - 1));
        req.col = 6'($urandom_range(0, NCOLS - 1));
        req.dest_row = 6'($urandom_range(0, NROWS - 1));
        req.dest_col = 6'($urandom_range(0, NCOLS - 1));
      end else if (pick < 92) begin
        req.operation = OP_PATH_RD;
        if (path_len != 0) req.path_index = 12'($urandom_range(0, path_len - 1));
      end
      // Remaining picks keep their fully random fields: off-grid and unused ops.
      send_request(req);
      if (i == count / 2) drain_results();
    end
  endtask

  initial begin
    repeat (12) @(posedge clk);
    rst_n <= 1'b1;
    test_map_writes();
    test_search_cases();
    test_unused_op();
    test_random_traffic(240);
    quiet = 1'b1;
    test_random_traffic(60);
    drain_results();
    if (errors == 0) $display("tb: success");
    else $display("tb: failure");
    $finish;
  end

  initial begin
    for (int i = 0; i < NCELLS; i++) begin
      free_map[i] = 1'b1;
      closed[i] = 1'b0;
      cost[i] = COST_UNREACHED;
      pdir[i] = PAR_E;
      path[i] = 0;
    end
    open_n = 0;
    path_len = 0;
  end

endmodule
